[rtl/core/servo_setpoint_slew_limiter_macros.svh]
// Assertion macros for the servo setpoint slew limiter.
// Used by the top level; expects clk and arst_n in the including scope.
`ifndef SERVO_SETPOINT_SLEW_LIMITER_MACROS_SVH
`define SERVO_SETPOINT_SLEW_LIMITER_MACROS_SVH

`ifndef ASSERT_OFF
// Concurrent check on clk, off while in reset.
`define SSSL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Concurrent check on clk that also holds during reset.
`define SSSL_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SSSL_ASSERT(lbl, prop, msg)
`define SSSL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/core/sssl_pkg.sv]
// Shared types and constants of the servo setpoint slew limiter.
// No dependencies.
package sssl_pkg;

	localparam int NUM_CH = 3;
	localparam int POS_W  = 8;
	localparam int DUTY_W = 12;
	localparam int CHAN_W = 2;

	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [DUTY_W-1:0] duty_t;
	typedef logic [CHAN_W-1:0] chan_t;

	// Item kind carried on tuser
	typedef enum logic {
		ACT_SET_TARGET = 1'b0,
		ACT_TICK       = 1'b1
	} action_t;

	localparam pos_t  POS_RESET  = 8'd128;
	localparam pos_t  STEP_RESET = 8'd6;
	localparam duty_t DUTY_BASE  = 12'd900;

endpackage

[rtl/core/servo_setpoint_slew_limiter.sv]
// Three-channel servo setpoint slew limiter, top level.
// The result of an input item passes through the input register, then the
// result register. Throughput: one item per cycle while m_axis_tready does
// not hold back the result register.
// Reset: all targets and actual positions 128, max_step 6, no result pending.
// Uses sssl_pkg, sssl_channel and servo_setpoint_slew_limiter_macros.svh.
`include "servo_setpoint_slew_limiter_macros.svh"

module servo_setpoint_slew_limiter (
	input  logic                 clk,
	input  logic                 arst_n,
	// max_step register write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  sssl_pkg::pos_t       cfg_data,
	// input items
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [15:0]          s_axis_tdata,  // channel[1:0], new_target[9:2], zero pad
	input  logic [0:0]           s_axis_tuser,  // action[0]
	// result items
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [63:0]          m_axis_tdata   // position_a/b/c, duty_a/b/c, zero pad
);
	import sssl_pkg::*;

	pos_t    max_step_q;
	pos_t    act_q [NUM_CH];
	pos_t    tgt_q [NUM_CH];

	logic    valid_s1;
	action_t action_s1;
	chan_t   chan_s1;
	pos_t    target_s1;

	logic    valid_s2;
	pos_t    pos_s2  [NUM_CH];
	duty_t   duty_s2 [NUM_CH];

	pos_t    pos_next  [NUM_CH];
	duty_t   duty_next [NUM_CH];
	logic    adv;
	logic    tick;

	// Register is always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_step_q <= STEP_RESET;
		end else if (cfg_valid) begin
			max_step_q <= cfg_data;
		end
	end

	// Handshake: stage 1 moves on when the result register is empty or its result is taken
	assign adv           = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign tick          = (action_s1 == ACT_TICK);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			action_s1 <= action_t'(s_axis_tuser[0]);
			chan_s1   <= s_axis_tdata[1:0];
			target_s1 <= s_axis_tdata[9:2];
		end
	end

	// Per-channel slew and duty
	for (genvar i = 0; i < NUM_CH; i++) begin : g_ch
		sssl_channel u_ch (
			.act       (act_q[i]),
			.tgt       (tgt_q[i]),
			.step      (max_step_q),
			.tick      (tick),
			.pos_next  (pos_next[i]),
			.duty_next (duty_next[i])
		);

		// Channel state: target on set, actual position on tick
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				act_q[i] <= POS_RESET;
				tgt_q[i] <= POS_RESET;
			end else if (adv) begin
				act_q[i] <= pos_next[i];
				if (!tick && chan_s1 == CHAN_W'(i)) begin
					tgt_q[i] <= target_s1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				pos_s2[i]  <= pos_next[i];
				duty_s2[i] <= duty_next[i];
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'b0, duty_s2[2], duty_s2[1], duty_s2[0],
	                        pos_s2[2], pos_s2[1], pos_s2[0]};

	// Checks
	`SSSL_ASSERT(a_stall_only_on_full_output,
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready),
		"input stalled while the result register could take data")
	`SSSL_ASSERT(a_set_keeps_positions,
		(adv && !tick) |=> (m_axis_tdata[23:0] == {act_q[2], act_q[1], act_q[0]}),
		"set-target item changed an actual position")
	`SSSL_ASSERT(a_duty_in_range,
		m_axis_tvalid |-> (duty_s2[0] >= DUTY_BASE && duty_s2[1] >= DUTY_BASE
			&& duty_s2[2] >= DUTY_BASE && duty_s2[0] <= 12'd2095
			&& duty_s2[1] <= 12'd2095 && duty_s2[2] <= 12'd2095),
		"duty word out of range")
	`SSSL_ASSERT_ALWAYS(a_no_result_in_reset,
		!arst_n |-> !m_axis_tvalid,
		"result valid during reset")

endmodule

[rtl/core/sssl_channel.sv]
// One servo channel: slew of the actual position toward the target and
// the PWM duty word of the resulting position. Depends on sssl_pkg.
module sssl_channel (
	input  sssl_pkg::pos_t  act,
	input  sssl_pkg::pos_t  tgt,
	input  sssl_pkg::pos_t  step,
	input  logic            tick,
	output sssl_pkg::pos_t  pos_next,
	output sssl_pkg::duty_t duty_next
);
	import sssl_pkg::*;

	logic [POS_W:0] a_w, t_w, s_w;
	pos_t           slewed;
	logic [14:0]    prod;

	// Limited move, never past the target
	always_comb begin
		a_w = {1'b0, act};
		t_w = {1'b0, tgt};
		s_w = {1'b0, step};
		if (a_w > t_w + s_w) begin
			slewed = act - step;
		end else if (a_w + s_w < t_w) begin
			slewed = act + step;
		end else begin
			slewed = tgt;
		end
		pos_next = tick ? slewed : act;
	end

	// duty = floor(pos*75/16) + 900, with 75 = 64 + 8 + 2 + 1
	always_comb begin
		prod = {1'b0, pos_next, 6'b0} + {4'b0, pos_next, 3'b0}
		     + {6'b0, pos_next, 1'b0} + {7'b0, pos_next};
		duty_next = {1'b0, prod[14:4]} + DUTY_BASE;
	end

endmodule
